>>> src/sm83alu_pkg.sv
// Shared types and codes for the 8-bit accumulator ALU with flags.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sm83alu_pkg;

  localparam int DataWidth   = 8;
  localparam int ActionWidth = 5;

  // Operation codes carried by the action field
  typedef enum logic [ActionWidth-1:0] {
    ACT_ADD  = 5'd0,
    ACT_ADC  = 5'd1,
    ACT_SUB  = 5'd2,
    ACT_SBC  = 5'd3,
    ACT_AND  = 5'd4,
    ACT_XOR  = 5'd5,
    ACT_OR   = 5'd6,
    ACT_CP   = 5'd7,
    ACT_INC  = 5'd8,
    ACT_DEC  = 5'd9,
    ACT_DAA  = 5'd10,
    ACT_CPL  = 5'd11,
    ACT_SCF  = 5'd12,
    ACT_CCF  = 5'd13,
    ACT_RLCA = 5'd14,
    ACT_RRCA = 5'd15,
    ACT_RLA  = 5'd16,
    ACT_RRA  = 5'd17,
    ACT_LDA  = 5'd18,
    ACT_LDF  = 5'd19
  } action_t;

  // Flag register, packed Z N H C from msb to lsb
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // Decimal adjust constants
  localparam logic [DataWidth-1:0] DaaHiAdj   = 8'h60;
  localparam logic [DataWidth-1:0] DaaLoAdj   = 8'h06;
  localparam logic [DataWidth-1:0] DaaHiLimit = 8'h99;
  localparam logic [3:0]           DaaLoLimit = 4'h9;

endpackage

`default_nettype wire

>>> src/sm83alu_cmd_if.sv
// Command channel: one beat carries an operation code and an operand byte.
// Depends on sm83alu_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface sm83alu_cmd_if;
  import sm83alu_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ActionWidth-1:0] action;
  logic [DataWidth-1:0]   operand;

  modport source (output valid, output action, output operand, input ready);
  modport sink   (input valid, input action, input operand, output ready);
endinterface

`default_nettype wire

>>> src/sm83alu_res_if.sv
// Result channel: one beat carries the produced byte and the four flags.
// Depends on sm83alu_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface sm83alu_res_if;
  import sm83alu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] value;
  logic                 zero_flag;
  logic                 subtract_flag;
  logic                 half_carry_flag;
  logic                 carry_flag;

  modport source (output valid, output value, output zero_flag, output subtract_flag,
                  output half_carry_flag, output carry_flag, input ready);
  modport sink   (input valid, input value, input zero_flag, input subtract_flag,
                  input half_carry_flag, input carry_flag, output ready);
endinterface

`default_nettype wire

>>> src/sm83alu_core.sv
// Combinational datapath: one operation against the current accumulator and flags.
// Depends on sm83alu_pkg for action codes, flag struct and DAA constants.
`timescale 1ns / 1ps
`default_nettype none

module sm83alu_core (
  input  wire logic [sm83alu_pkg::ActionWidth-1:0] action,
  input  wire logic [sm83alu_pkg::DataWidth-1:0]   operand,
  input  wire logic [sm83alu_pkg::DataWidth-1:0]   acc,
  input  wire sm83alu_pkg::flags_t                 flags,
  output logic      [sm83alu_pkg::DataWidth-1:0]   acc_next,
  output sm83alu_pkg::flags_t                      flags_next,
  output logic      [sm83alu_pkg::DataWidth-1:0]   value
);
  import sm83alu_pkg::*;

  logic                 cin;
  logic [DataWidth:0]   sum;
  logic [4:0]           half_sum;
  logic [DataWidth:0]   diff;
  logic [4:0]           half_diff;
  logic [DataWidth-1:0] inc_res;
  logic [DataWidth-1:0] dec_res;
  logic [DataWidth-1:0] logic_res;
  logic [DataWidth-1:0] daa_res;
  logic                 daa_c;

  // Carry in only for the with-carry forms
  assign cin = (action == ACT_ADC || action == ACT_SBC) ? flags.c : 1'b0;

  // Shared add and subtract with nibble carries
  assign sum       = {1'b0, acc} + {1'b0, operand} + {{DataWidth{1'b0}}, cin};
  assign half_sum  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'b0, cin};
  assign diff      = {1'b0, acc} - {1'b0, operand} - {{DataWidth{1'b0}}, cin};
  assign half_diff = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'b0, cin};

  assign inc_res = operand + 8'd1;
  assign dec_res = operand - 8'd1;

  always_comb begin
    unique case (action)
      ACT_AND: logic_res = acc & operand;
      ACT_XOR: logic_res = acc ^ operand;
      default: logic_res = acc | operand;
    endcase
  end

  // Decimal adjust: upper digit decided on the unadjusted accumulator
  always_comb begin
    daa_res = acc;
    daa_c   = flags.c;
    if (!flags.n) begin
      if (flags.c || acc > DaaHiLimit) begin
        daa_res = daa_res + DaaHiAdj;
        daa_c   = 1'b1;
      end
      if (flags.h || acc[3:0] > DaaLoLimit) begin
        daa_res = daa_res + DaaLoAdj;
      end
    end else begin
      if (flags.c) begin
        daa_res = daa_res - DaaHiAdj;
      end
      if (flags.h) begin
        daa_res = daa_res - DaaLoAdj;
      end
    end
  end

  // Operation select
  always_comb begin
    acc_next   = acc;
    flags_next = flags;
    value      = acc;
    unique case (action)
      ACT_ADD, ACT_ADC: begin
        acc_next   = sum[DataWidth-1:0];
        flags_next = '{z: (sum[DataWidth-1:0] == '0), n: 1'b0,
                       h: half_sum[4], c: sum[DataWidth]};
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        if (action != ACT_CP) acc_next = diff[DataWidth-1:0];
        flags_next = '{z: (diff[DataWidth-1:0] == '0), n: 1'b1,
                       h: half_diff[4], c: diff[DataWidth]};
      end
      ACT_AND: begin
        acc_next   = logic_res;
        flags_next = '{z: (logic_res == '0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      ACT_XOR, ACT_OR: begin
        acc_next   = logic_res;
        flags_next = '{z: (logic_res == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ACT_INC: begin
        flags_next = '{z: (inc_res == '0), n: 1'b0, h: (operand[3:0] == 4'hf),
                       c: flags.c};
      end
      ACT_DEC: begin
        flags_next = '{z: (dec_res == '0), n: 1'b1, h: (operand[3:0] == 4'h0),
                       c: flags.c};
      end
      ACT_DAA: begin
        acc_next   = daa_res;
        flags_next = '{z: (daa_res == '0), n: flags.n, h: 1'b0, c: daa_c};
      end
      ACT_CPL: begin
        acc_next   = ~acc;
        flags_next = '{z: flags.z, n: 1'b1, h: 1'b1, c: flags.c};
      end
      ACT_SCF: flags_next = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      ACT_CCF: flags_next = '{z: flags.z, n: 1'b0, h: 1'b0, c: ~flags.c};
      ACT_RLCA: begin
        acc_next   = {acc[DataWidth-2:0], acc[DataWidth-1]};
        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[DataWidth-1]};
      end
      ACT_RRCA: begin
        acc_next   = {acc[0], acc[DataWidth-1:1]};
        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
      end
      ACT_RLA: begin
        acc_next   = {acc[DataWidth-2:0], flags.c};
        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[DataWidth-1]};
      end
      ACT_RRA: begin
        acc_next   = {flags.c, acc[DataWidth-1:1]};
        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
      end
      ACT_LDA: acc_next = operand;
      ACT_LDF: flags_next = flags_t'(operand[DataWidth-1:DataWidth-4]);
      default: ;  // unused codes leave everything as is
    endcase

    // INC and DEC report the changed operand, all else the new accumulator
    priority if (action == ACT_INC) begin
      value = inc_res;
    end else if (action == ACT_DEC) begin
      value = dec_res;
    end else begin
      value = acc_next;
    end
  end

endmodule

`default_nettype wire

>>> src/eight_bit_alu_with_flags.sv
// Top level of the 8-bit accumulator ALU with flags: stage and result registers.
// Depends on sm83alu_pkg, sm83alu_cmd_if, sm83alu_res_if and sm83alu_core.
`timescale 1ns / 1ps
`default_nettype none

// Accumulator ALU with Z, N, H and C flags. Each command beat names one operation
// and an operand byte and yields exactly one result beat: the new accumulator (or,
// for INC and DEC, the changed operand) and the four flags after the operation.
// Throughput is one beat per cycle while the result side keeps taking beats. The command
// beat lands in the stage register when it is taken, then passes through the adder and
// flag logic into the result register once that register is free or draining, and its
// result is offered from there. The accumulator and flags sit beside the result register,
// so each operation sees the state left by the one before it with no bubble. Reset
// clears the accumulator and all flags.
module eight_bit_alu_with_flags (
  input wire logic    clk,
  input wire logic    rst,
  sm83alu_cmd_if.sink cmd,
  sm83alu_res_if.source res
);
  import sm83alu_pkg::*;

  logic                   stage_valid;
  logic [ActionWidth-1:0] stage_action;
  logic [DataWidth-1:0]   stage_operand;
  logic                   res_valid;
  logic [DataWidth-1:0]   res_value;
  flags_t                 res_flags;
  logic [DataWidth-1:0]   acc;
  flags_t                 flags;
  logic [DataWidth-1:0]   acc_next;
  flags_t                 flags_next;
  logic [DataWidth-1:0]   value_next;
  logic                   advance;

  // Stage moves into the result register when that slot is free or draining
  assign advance   = stage_valid && (!res_valid || res.ready);
  assign cmd.ready = !stage_valid || advance;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      stage_action  <= cmd.action;
      stage_operand <= cmd.operand;
    end
  end

  sm83alu_core u_core (
    .action     (stage_action),
    .operand    (stage_operand),
    .acc        (acc),
    .flags      (flags),
    .acc_next   (acc_next),
    .flags_next (flags_next),
    .value      (value_next)
  );

  // Architectural state and result register update together
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      acc       <= '0;
      flags     <= '0;
    end else begin
      if (advance) begin
        res_valid <= 1'b1;
        acc       <= acc_next;
        flags     <= flags_next;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (advance) begin
      res_value <= value_next;
      res_flags <= flags_next;
    end
  end

  assign res.valid           = res_valid;
  assign res.value           = res_value;
  assign res.zero_flag       = res_flags.z;
  assign res.subtract_flag   = res_flags.n;
  assign res.half_carry_flag = res_flags.h;
  assign res.carry_flag      = res_flags.c;

  // A computed beat always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("computed beat did not reach result register");

  // State holds while nothing is computed
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> (acc == $past(acc)) && (flags == $past(flags)))
    else $error("state changed without a beat");

  // Delivered flags mirror the flag register
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_flags == flags))
    else $error("result flags differ from flag register");

  // INC and DEC leave the accumulator alone
  a_incdec_keeps_acc: assert property (@(posedge clk) disable iff (rst)
    advance && (stage_action == ACT_INC || stage_action == ACT_DEC)
      |=> acc == $past(acc))
    else $error("INC or DEC changed the accumulator");

endmodule

`default_nettype wire
